### hw/rtl/mau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, opcodes and pipeline sideband types of the modular unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int ORDER_W          = 31;
    localparam int CMD_W            = 3;
    localparam int PROD_W           = 2 * ORDER_W;
    localparam int OPERAND_BITS_DEF = 32;
    localparam logic [ORDER_W-1:0] ORDER_MIN = ORDER_W'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_REDUCE  = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_REM_ELT = 3'd4,
        CMD_REM_INT = 3'd5,
        CMD_CMP     = 3'd6,
        CMD_NONE    = 3'd7
    } cmd_t;

    // sideband through the operand reduction pipe
    typedef struct packed {
        cmd_t               cmd;
        logic               neg_a;
        logic               neg_b;
        logic               b_zero;
        logic [ORDER_W-1:0] m;
    } red_side_t;

    // sideband through the product / remainder pipe
    typedef struct packed {
        cmd_t               cmd;
        logic [ORDER_W-1:0] sum;
        logic [ORDER_W-1:0] diff;
        logic [ORDER_W-1:0] ra;
        logic               less;
        logic               equal;
        logic               b_zero;
        logic               rb_zero;
    } mul_side_t;

endpackage
`default_nettype wire

### hw/rtl/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Reduce, add, sub, mul, remainder and compare modulo a configured order.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Beat
// input   | in_valid, in_ready, cmd, operand_a/b      | one operation
// output  | out_valid, out_ready, result, less, equal, | one result
//         | error                                      |
// config  | cfg_wr_en, cfg_wr_data                    | field order, no wait
//
// One beat per cycle sustained while the output is not stalled. Each beat
// passes stage A, the operand reduction pipe, stages B and C, the product /
// element remainder pipe and the output register; both pipes are bit-per-stage.
// Reset clears all valid bits and loads order 2. A stall on the output
// freezes the whole pipe; in_ready is low only while a result is held.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
    parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mau_pkg::ORDER_W-1:0] cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [mau_pkg::CMD_W-1:0]   cmd,
    input  wire logic [OPERAND_BITS-1:0]     operand_a,
    input  wire logic [OPERAND_BITS-1:0]     operand_b,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mau_pkg::ORDER_W-1:0]      result,
    output logic                             less,
    output logic                             equal,
    output logic                             error
);
    import mau_pkg::*;

    logic en;
    logic [ORDER_W-1:0] order_reg;

    // a zero or one order behaves as two; clamp at write time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            order_reg <= ORDER_MIN;
        end else if (cfg_wr_en) begin
            order_reg <= (cfg_wr_data < ORDER_MIN) ? ORDER_MIN : cfg_wr_data;
        end
    end

    // whole pipe advances unless a result is held unaccepted
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---- stage A: magnitudes and signs ----
    logic                    a_vld_reg;
    logic [OPERAND_BITS-1:0] a_mag_a_reg, a_mag_b_reg;
    red_side_t               a_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            // negating the most negative value gives its magnitude as unsigned
            a_mag_a_reg       <= operand_a[OPERAND_BITS-1] ? (~operand_a + 1'b1) : operand_a;
            a_mag_b_reg       <= operand_b[OPERAND_BITS-1] ? (~operand_b + 1'b1) : operand_b;
            a_side_reg.cmd    <= cmd_t'(cmd);
            a_side_reg.neg_a  <= operand_a[OPERAND_BITS-1];
            a_side_reg.neg_b  <= operand_b[OPERAND_BITS-1];
            a_side_reg.b_zero <= (operand_b == '0);
            a_side_reg.m      <= order_reg;
        end
    end

    // ---- operand reduction pipe ----
    logic               p1_vld;
    logic [ORDER_W-1:0] p1_r0, p1_r1;
    red_side_t          p1_side;

    mau_mod_pipe #(
        .DW (OPERAND_BITS),
        .SW ($bits(red_side_t))
    ) u_red_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (a_vld_reg),
        .x0       (a_mag_a_reg),
        .x1       (a_mag_b_reg),
        .d0       (a_side_reg.m),
        .d1       (a_side_reg.m),
        .side_in  (a_side_reg),
        .out_vld  (p1_vld),
        .r0       (p1_r0),
        .r1       (p1_r1),
        .side_out (p1_side)
    );

    // ---- stage B: sign fix to residues ----
    logic               b_vld_reg;
    logic [ORDER_W-1:0] b_ra_reg, b_rb_reg, b_m_reg;
    cmd_t               b_cmd_reg;
    logic               b_bz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= p1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            b_ra_reg  <= (p1_side.neg_a && p1_r0 != '0) ? (p1_side.m - p1_r0) : p1_r0;
            b_rb_reg  <= (p1_side.neg_b && p1_r1 != '0) ? (p1_side.m - p1_r1) : p1_r1;
            b_m_reg   <= p1_side.m;
            b_cmd_reg <= p1_side.cmd;
            b_bz_reg  <= p1_side.b_zero;
        end
    end

    // ---- stage C: product, modular sum/difference, flags ----
    logic [ORDER_W:0]   sum_w;
    logic               c_vld_reg;
    logic [PROD_W-1:0]  c_prod_reg;
    logic [ORDER_W-1:0] c_rb_reg, c_m_reg;
    mul_side_t          c_side_reg;

    assign sum_w = {1'b0, b_ra_reg} + {1'b0, b_rb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            c_prod_reg         <= PROD_W'(b_ra_reg) * PROD_W'(b_rb_reg);
            c_rb_reg           <= b_rb_reg;
            c_m_reg            <= b_m_reg;
            c_side_reg.cmd     <= b_cmd_reg;
            c_side_reg.sum     <= (sum_w >= {1'b0, b_m_reg}) ?
                                  ORDER_W'(sum_w - {1'b0, b_m_reg}) : ORDER_W'(sum_w);
            c_side_reg.diff    <= (b_ra_reg >= b_rb_reg) ? (b_ra_reg - b_rb_reg) :
                                  (b_ra_reg - b_rb_reg + b_m_reg);
            c_side_reg.ra      <= b_ra_reg;
            c_side_reg.less    <= (b_ra_reg < b_rb_reg);
            c_side_reg.equal   <= (b_ra_reg == b_rb_reg);
            c_side_reg.b_zero  <= b_bz_reg;
            c_side_reg.rb_zero <= (b_rb_reg == '0);
        end
    end

    // ---- product mod m and ra mod rb pipe ----
    logic               p2_vld;
    logic [ORDER_W-1:0] p2_r0, p2_r1;
    mul_side_t          p2_side;

    mau_mod_pipe #(
        .DW (PROD_W),
        .SW ($bits(mul_side_t))
    ) u_mul_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (c_vld_reg),
        .x0       (c_prod_reg),
        .x1       ({{(PROD_W-ORDER_W){1'b0}}, c_side_reg.ra}),
        .d0       (c_m_reg),
        .d1       (c_rb_reg),
        .side_in  (c_side_reg),
        .out_vld  (p2_vld),
        .r0       (p2_r0),
        .r1       (p2_r1),
        .side_out (p2_side)
    );

    // ---- output register ----
    logic [ORDER_W-1:0] res_next;
    logic               err_next;

    // with a zero divisor the remainder lane passes ra through unchanged
    always_comb
    begin
        res_next = '0;
        err_next = 1'b0;
        case (p2_side.cmd)
            CMD_REDUCE:  res_next = p2_side.ra;
            CMD_ADD:     res_next = p2_side.sum;
            CMD_SUB:     res_next = p2_side.diff;
            CMD_MUL:     res_next = p2_r0;
            CMD_REM_ELT:
            begin
                err_next = p2_side.rb_zero;
                res_next = p2_side.rb_zero ? '0 : p2_r1;
            end
            CMD_REM_INT:
            begin
                err_next = p2_side.b_zero;
                res_next = p2_side.b_zero ? '0 : p2_r1;
            end
            default:     res_next = '0;
        endcase
    end

    logic               out_vld_reg;
    logic [ORDER_W-1:0] result_reg;
    logic               less_reg, equal_reg, error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= p2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            result_reg <= res_next;
            less_reg   <= p2_side.less;
            equal_reg  <= p2_side.equal;
            error_reg  <= err_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign result    = result_reg;
    assign less      = less_reg;
    assign equal     = equal_reg;
    assign error     = error_reg;

    // ---- assertions ----
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> result == '0)
        else $error("error beat with nonzero result");

    a_less_eq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(less && equal))
        else $error("less and equal both set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result) && $stable(error))
        else $error("held result changed during stall");

endmodule
`default_nettype wire

### hw/rtl/mau_mod_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mau_mod_pipe
// Two-lane pipelined remainder, one dividend bit per stage (restoring).
// ----------------------------------------------------------------------------
module mau_mod_pipe #(
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [DW-1:0]               x0,
    input  wire logic [DW-1:0]               x1,
    input  wire logic [mau_pkg::ORDER_W-1:0] d0,
    input  wire logic [mau_pkg::ORDER_W-1:0] d1,
    input  wire logic [SW-1:0]               side_in,
    output logic                             out_vld,
    output logic [mau_pkg::ORDER_W-1:0]      r0,
    output logic [mau_pkg::ORDER_W-1:0]      r1,
    output logic [SW-1:0]                    side_out
);
    import mau_pkg::*;

    // partial remainder stays below d; d == 0 just shifts the dividend in
    function automatic logic [ORDER_W-1:0] step(input logic [ORDER_W-1:0] r,
                                                input logic b,
                                                input logic [ORDER_W-1:0] d);
        logic [ORDER_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[ORDER_W-1:0];
    endfunction

    logic               vld_reg [DW];
    logic [ORDER_W-1:0] rem0_reg[DW];
    logic [ORDER_W-1:0] rem1_reg[DW];
    logic [DW-1:0]      xs0_reg [DW];
    logic [DW-1:0]      xs1_reg [DW];
    logic [ORDER_W-1:0] d0_reg  [DW];
    logic [ORDER_W-1:0] d1_reg  [DW];
    logic [SW-1:0]      side_reg[DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic               v_in;
        logic [ORDER_W-1:0] r0_in, r1_in, d0_in, d1_in;
        logic [DW-1:0]      x0_in, x1_in;
        logic [SW-1:0]      s_in;

        if (k == 0) begin : g_first
            assign v_in  = in_vld;
            assign r0_in = '0;
            assign r1_in = '0;
            assign x0_in = x0;
            assign x1_in = x1;
            assign d0_in = d0;
            assign d1_in = d1;
            assign s_in  = side_in;
        end else begin : g_next
            assign v_in  = vld_reg[k-1];
            assign r0_in = rem0_reg[k-1];
            assign r1_in = rem1_reg[k-1];
            assign x0_in = xs0_reg[k-1];
            assign x1_in = xs1_reg[k-1];
            assign d0_in = d0_reg[k-1];
            assign d1_in = d1_reg[k-1];
            assign s_in  = side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                rem0_reg[k] <= step(r0_in, x0_in[DW-1], d0_in);
                rem1_reg[k] <= step(r1_in, x1_in[DW-1], d1_in);
                xs0_reg[k]  <= x0_in << 1;
                xs1_reg[k]  <= x1_in << 1;
                d0_reg[k]   <= d0_in;
                d1_reg[k]   <= d1_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_vld  = vld_reg[DW-1];
    assign r0       = rem0_reg[DW-1];
    assign r1       = rem1_reg[DW-1];
    assign side_out = side_reg[DW-1];

endmodule
`default_nettype wire
